[rtl/kfi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared codes and field widths for the keyframe linear interpolator
// no dependencies

package kfi_pkg;

    localparam int TIME_W  = 32;
    localparam int COORD_W = 32;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    localparam logic [1:0] PT_PAYLOAD = 2'd0;
    localparam logic [1:0] PT_LAST    = 2'd3;

endpackage

`default_nettype wire

[rtl/kfi_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// generic simple dual port ram, one write and one registered read port
// no dependencies

module kfi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/kfi_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider for the blend fraction u = (num << FRAC_BITS) / den, clamped to 1.0
// depends on kfi_pkg

module kfi_div import kfi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  wire  [TIME_W-1:0]      num,
    input  wire  [TIME_W-1:0]      den,
    output logic                   done,
    output logic [FRAC_BITS:0]     quot
);

    localparam int UW  = FRAC_BITS + 1;
    localparam int CNW = $clog2(FRAC_BITS + 1);
    localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNW-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg, den_next;
    logic [UW-1:0]     q_reg, q_next;
    logic [TIME_W:0]   rem2;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        rem2      = {rem_reg, 1'b0};
        if (start) begin
            den_next = den;
            if (num >= den) begin
                // fraction reaches one
                q_next    = ONE;
                done_next = 1'b1;
            end else begin
                rem_next  = num;
                q_next    = '0;
                cnt_next  = CNW'(FRAC_BITS);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (rem2 >= {1'b0, den_reg}) begin
                rem_next = TIME_W'(rem2 - {1'b0, den_reg});
                q_next   = {q_reg[UW-2:0], 1'b1};
            end else begin
                rem_next = rem2[TIME_W-1:0];
                q_next   = {q_reg[UW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

    a_q_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> q_reg <= ONE)
        else $error("divider fraction above one");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider started while busy");

endmodule

`default_nettype wire

[rtl/keyframe_linear_interpolator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// keyframe table with linear scan, fraction divider and per-point blend
// depends on kfi_pkg, kfi_ram, kfi_div
//
//  channel  direction  contents
//  s_*      in         load / query / clear requests (kind, point in tuser)
//  m_*      out        results (status, point_id in tuser, last in tlast)
//  cfg_*    in         height offset write
//
// load, clear and short queries pass the response state, held by output stall.
// query: the scan reads one keyframe time per cycle from the time memory, so it
// grows with the table; the divider and the per-point blend follow.
// memories hold no reset contents; reset empties the table, reloads the offset.
// requests are taken only while the sequencer idles; a result held in the
// output register does not block the next request.

module keyframe_linear_interpolator_top import kfi_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16,
    parameter int ANGLE_BITS  = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // time, x, y, z, heading, extra_points_present
    input  wire  [((129+ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    // kind, point
    input  wire  [7:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // out_x, out_y, out_z, out_heading, extra_points_valid
    output logic [((97+ANGLE_BITS+7)/8)*8-1:0]  m_tdata,
    // status, point_id
    output logic [7:0]  m_tuser,
    output logic        m_tlast,
    input  wire         cfg_wr_en,
    input  wire  [31:0] cfg_wr_data
);

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int A      = ANGLE_BITS;
    localparam int UW     = FRAC_BITS + 1;
    localparam int PRW    = COORD_W + 2 + UW;
    localparam int HPW    = A + 2 + UW;
    localparam int OUT_TW = ((97 + ANGLE_BITS + 7) / 8) * 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic signed [PRW-1:0] RND  = PRW'(1) << (FRAC_BITS - 1);
    localparam logic signed [HPW-1:0] HRND = HPW'(1) << (FRAC_BITS - 1);
    localparam logic signed [A:0] HALF = (A+1)'(1) << (A - 1);
    localparam logic signed [A:0] FULL_T = (A+1)'(1) << A;
    localparam logic signed [PRW-1:0] SMAX = PRW'(32'sh7FFFFFFF);
    localparam logic signed [PRW-1:0] SMIN = -PRW'(64'sh80000000);

    typedef enum logic [3:0] {
        S_IDLE, S_RESP, S_T0, S_TL, S_SCAN, S_DIV,
        S_M0, S_M1, S_M2, S_C0, S_C1, S_C2, S_C3
    } state_t;

    // input fields
    kind_t             in_kind;
    logic [1:0]        in_point;
    logic [TIME_W-1:0] in_time;
    logic [3*COORD_W-1:0] in_xyz;
    logic [A-1:0]      in_head;
    logic              in_flag;

    assign in_kind  = kind_t'(s_tuser[1:0]);
    assign in_point = s_tuser[3:2];
    assign in_time  = s_tdata[31:0];
    assign in_xyz   = s_tdata[127:32];
    assign in_head  = s_tdata[128 +: A];
    assign in_flag  = s_tdata[128 + A];

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              tail_reg, tail_next;
    logic [31:0]       hoff_reg;
    status_t           rst_reg, rst_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] t0_reg, t0_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [IW-1:0]     ia_reg, ia_next;
    logic [IW-1:0]     ib_reg, ib_next;
    logic [UW-1:0]     u_reg, u_next;
    logic [A-1:0]      ha_reg, ha_next;
    logic              fa_reg, fa_next;
    logic signed [A:0] hraw_reg, hraw_next;
    logic              valid_reg, valid_next;
    logic [1:0]        p_reg, p_next;
    logic [3*COORD_W-1:0] a_reg, a_next;
    logic signed [PRW-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [HPW-1:0] ph_reg, ph_next;

    logic              ov_reg, ov_next;
    status_t           os_reg, os_next;
    logic [1:0]        op_reg, op_next;
    logic [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [A-1:0]      oh_reg, oh_next;
    logic              oe_reg, oe_next;
    logic              ol_reg, ol_next;

    // memories
    logic              tm_we, mm_we, cm_we;
    logic [IW-1:0]     tm_waddr, tm_raddr, mm_raddr;
    logic [IW+1:0]     cm_waddr, cm_raddr;
    logic [TIME_W-1:0] tm_rdata;
    logic [A:0]        mm_rdata;
    logic [3*COORD_W-1:0] cm_rdata;

    logic              div_start, div_done;
    logic [TIME_W-1:0] div_num, div_den;
    logic [UW-1:0]     div_q;

    kfi_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_times (
        .aclk(aclk), .we(tm_we), .waddr(tm_waddr), .wdata(in_time),
        .raddr(tm_raddr), .rdata(tm_rdata)
    );

    kfi_ram #(.WIDTH(A + 1), .DEPTH(TABLE_DEPTH)) u_meta (
        .aclk(aclk), .we(mm_we), .waddr(tm_waddr), .wdata({in_flag, in_head}),
        .raddr(mm_raddr), .rdata(mm_rdata)
    );

    kfi_ram #(.WIDTH(3 * COORD_W), .DEPTH(4 * TABLE_DEPTH)) u_coords (
        .aclk(aclk), .we(cm_we), .waddr(cm_waddr), .wdata(in_xyz),
        .raddr(cm_raddr), .rdata(cm_rdata)
    );

    kfi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .done(div_done), .quot(div_q)
    );

    logic [CW-1:0]  cnt_m1;
    logic           acc, out_free;
    logic [HPW-1:0] hv;
    logic signed [COORD_W:0]   dx, dy, dz;
    logic signed [PRW-1:0] rx, ry, rz, vx, vy, vz, zs;
    logic signed [HPW-1:0] rh;
    logic signed [A:0]     hr;

    assign cnt_m1   = count_reg - CW'(1);
    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        rst_next   = rst_reg;
        t_next     = t_reg;
        t0_next    = t0_reg;
        prev_next  = prev_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        u_next     = u_reg;
        ha_next    = ha_reg;
        fa_next    = fa_reg;
        hraw_next  = hraw_reg;
        valid_next = valid_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        ph_next    = ph_reg;
        ov_next    = ov_reg && !m_tready;
        os_next    = os_reg;
        op_next    = op_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        oh_next    = oh_reg;
        oe_next    = oe_reg;
        ol_next    = ol_reg;

        tm_we     = 1'b0;
        mm_we     = 1'b0;
        cm_we     = 1'b0;
        tm_waddr  = count_reg[IW-1:0];
        cm_waddr  = {count_reg[IW-1:0], in_point};
        tm_raddr  = '0;
        mm_raddr  = ia_reg;
        cm_raddr  = {ia_reg, p_reg};
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        dx = '0; dy = '0; dz = '0; hr = '0;
        rx = '0; ry = '0; rz = '0; rh = '0;
        vx = '0; vy = '0; vz = '0; zs = '0; hv = '0;

        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    case (in_kind)
                        KIND_LOAD: begin
                            state_next = S_RESP;
                            rst_next   = ST_OK;
                            if (in_point == PT_PAYLOAD) begin
                                if (count_reg >= DEPTH_C) begin
                                    tail_next = 1'b1;
                                    rst_next  = ST_FULL;
                                end else begin
                                    tm_we      = 1'b1;
                                    mm_we      = 1'b1;
                                    cm_we      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                    tail_next  = 1'b0;
                                end
                            end else if (tail_reg) begin
                                rst_next = ST_FULL;
                            end else if (count_reg == '0) begin
                                rst_next = ST_FEW;
                            end else begin
                                cm_we    = 1'b1;
                                cm_waddr = {cnt_m1[IW-1:0], in_point};
                            end
                        end
                        KIND_QUERY: begin
                            t_next = in_time;
                            if (count_reg < CW'(2)) begin
                                rst_next   = ST_FEW;
                                state_next = S_RESP;
                            end else begin
                                tm_raddr   = '0;
                                state_next = S_T0;
                            end
                        end
                        KIND_CLEAR: begin
                            count_next = '0;
                            tail_next  = 1'b0;
                            rst_next   = ST_OK;
                            state_next = S_RESP;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    os_next = rst_reg;
                    op_next = '0;
                    ox_next = '0;
                    oy_next = '0;
                    oz_next = '0;
                    oh_next = '0;
                    oe_next = 1'b0;
                    ol_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_T0: begin
                t0_next    = tm_rdata;
                tm_raddr   = cnt_m1[IW-1:0];
                state_next = S_TL;
            end
            S_TL: begin
                u_next = '0;
                if (t_reg <= t0_reg) begin
                    ia_next    = '0;
                    ib_next    = '0;
                    state_next = S_M0;
                end else if (t_reg >= tm_rdata) begin
                    ia_next    = cnt_m1[IW-1:0];
                    ib_next    = cnt_m1[IW-1:0];
                    state_next = S_M0;
                end else begin
                    // scan from keyframe one; the last time bounds it
                    tm_raddr   = IW'(1);
                    ib_next    = IW'(1);
                    prev_next  = t0_reg;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tm_rdata < t_reg) begin
                    prev_next = tm_rdata;
                    ib_next   = ib_reg + IW'(1);
                    tm_raddr  = ib_reg + IW'(1);
                end else begin
                    ia_next    = ib_reg - IW'(1);
                    div_start  = 1'b1;
                    div_num    = (t_reg > prev_reg) ? t_reg - prev_reg : '0;
                    div_den    = (tm_rdata > prev_reg) ? tm_rdata - prev_reg
                                                       : TIME_W'(1);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    u_next     = div_q;
                    state_next = S_M0;
                end
            end
            S_M0: begin
                mm_raddr   = ia_reg;
                state_next = S_M1;
            end
            S_M1: begin
                ha_next    = mm_rdata[A-1:0];
                fa_next    = mm_rdata[A];
                mm_raddr   = ib_reg;
                state_next = S_M2;
            end
            S_M2: begin
                valid_next = fa_reg & mm_rdata[A];
                hr = $signed({1'b0, mm_rdata[A-1:0]}) - $signed({1'b0, ha_reg});
                // shortest wrapped difference, exact half turn keeps its sign
                if (hr > HALF) begin
                    hraw_next = hr - FULL_T;
                end else if (hr < -HALF) begin
                    hraw_next = hr + FULL_T;
                end else begin
                    hraw_next = hr;
                end
                p_next     = PT_PAYLOAD;
                state_next = S_C0;
            end
            S_C0: begin
                cm_raddr   = {ia_reg, p_reg};
                state_next = S_C1;
            end
            S_C1: begin
                a_next     = cm_rdata;
                cm_raddr   = {ib_reg, p_reg};
                state_next = S_C2;
            end
            S_C2: begin
                dx = $signed({cm_rdata[31], cm_rdata[31:0]})
                   - $signed({a_reg[31], a_reg[31:0]});
                dy = $signed({cm_rdata[63], cm_rdata[63:32]})
                   - $signed({a_reg[63], a_reg[63:32]});
                dz = $signed({cm_rdata[95], cm_rdata[95:64]})
                   - $signed({a_reg[95], a_reg[95:64]});
                px_next = PRW'(dx * $signed({1'b0, u_reg}));
                py_next = PRW'(dy * $signed({1'b0, u_reg}));
                pz_next = PRW'(dz * $signed({1'b0, u_reg}));
                ph_next = HPW'(hraw_reg * $signed({1'b0, u_reg}));
                state_next = S_C3;
            end
            S_C3: begin
                rx = (px_reg + RND) >>> FRAC_BITS;
                ry = (py_reg + RND) >>> FRAC_BITS;
                rz = (pz_reg + RND) >>> FRAC_BITS;
                rh = (ph_reg + HRND) >>> FRAC_BITS;
                vx = PRW'($signed(a_reg[31:0])) + rx;
                vy = PRW'($signed(a_reg[63:32])) + ry;
                vz = PRW'($signed(a_reg[95:64])) + rz;
                zs = vz + PRW'($signed(hoff_reg));
                hv = HPW'(ha_reg) + HPW'(rh);
                if (out_free) begin
                    ov_next = 1'b1;
                    os_next = ST_OK;
                    op_next = p_reg;
                    ox_next = vx[31:0];
                    oy_next = vy[31:0];
                    if (zs > SMAX) begin
                        oz_next = 32'h7FFFFFFF;
                    end else if (zs < SMIN) begin
                        oz_next = 32'h80000000;
                    end else begin
                        oz_next = zs[31:0];
                    end
                    oh_next = (p_reg == PT_PAYLOAD) ? hv[A-1:0] : '0;
                    oe_next = valid_reg;
                    ol_next = !valid_reg || (p_reg == PT_LAST);
                    if (!valid_reg || (p_reg == PT_LAST)) begin
                        state_next = S_IDLE;
                    end else begin
                        p_next     = p_reg + 2'd1;
                        state_next = S_C0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tail_reg  <= 1'b0;
            hoff_reg  <= 32'd72090;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en) begin
                hoff_reg <= cfg_wr_data;
            end
        end
        rst_reg   <= rst_next;
        t_reg     <= t_next;
        t0_reg    <= t0_next;
        prev_reg  <= prev_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        u_reg     <= u_next;
        ha_reg    <= ha_next;
        fa_reg    <= fa_next;
        hraw_reg  <= hraw_next;
        valid_reg <= valid_next;
        p_reg     <= p_next;
        a_reg     <= a_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        ph_reg    <= ph_next;
        os_reg    <= os_next;
        op_reg    <= op_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        oh_reg    <= oh_next;
        oe_reg    <= oe_next;
        ol_reg    <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = OUT_TW'({oe_reg, oh_reg, oz_reg, oy_reg, ox_reg});
    assign m_tuser  = {4'd0, op_reg, os_reg};
    assign m_tlast  = ol_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("keyframe count beyond table depth");

    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("fraction ready outside divide wait");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && os_reg != ST_OK) |-> m_tlast)
        else $error("error result not last");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> {1'b0, ib_reg} < {1'b0, count_reg})
        else $error("scan ran past the stored keyframes");

endmodule

`default_nettype wire

[tb/sv/keyframe_linear_interpolator_checker.sv]
`timescale 1ns / 1ps
// result checker for the keyframe linear interpolator: watches both stream channels,
// keeps its own keyframe table and height offset, and compares every result in order
// depends on kfi_pkg

module keyframe_linear_interpolator_checker import kfi_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [151:0] s_tdata,
    input  wire  [7:0]   s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [119:0] m_tdata,
    input  wire  [7:0]   m_tuser,
    input  wire          m_tlast,
    input  wire          cfg_wr_en,
    input  wire  [31:0]  cfg_wr_data,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           queries_seen
);

    localparam int DEPTH = 1024;
    localparam int FB    = 16;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  point_id;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] hdg;
        logic        xvalid;
        logic        last;
    } frame_out_t;

    frame_out_t expected_frames[$];

    logic [31:0] kt [DEPTH];
    logic [31:0] kc [DEPTH*12];
    logic [15:0] kh [DEPTH];
    logic        kx [DEPTH];
    int          kcount;
    bit          dropped_tail;
    logic [31:0] hoffset;

    function automatic longint lerp_q16(longint a, longint b, longint u);
        longint p;
        p = (b - a) * u + (64'sd1 <<< (FB - 1));
        return a + (p >>> FB);
    endfunction

    function automatic frame_out_t status_only(logic [1:0] st);
        frame_out_t f;
        f = '0;
        f.status = st;
        f.last = 1'b1;
        return f;
    endfunction

    task automatic predict_query(logic [31:0] t);
        int ia, ib, n;
        longint u, num, dt, ha, hb, raw, z;
        logic xv;
        frame_out_t f;
        u = 0;
        if (kcount < 2) begin
            expected_frames.push_back(status_only(ST_FEW));
            return;
        end
        if (t <= kt[0]) begin
            ia = 0; ib = 0;
        end else if (t >= kt[kcount-1]) begin
            ia = kcount - 1; ib = kcount - 1;
        end else begin
            ib = 1;
            while (ib < kcount && kt[ib] < t) ib++;
            if (ib >= kcount) ib = kcount - 1;
            ia = ib - 1;
            num = (t > kt[ia]) ? longint'(t) - longint'(kt[ia]) : 0;
            dt = (kt[ib] > kt[ia]) ? longint'(kt[ib]) - longint'(kt[ia]) : 1;
            u = (num <<< FB) / dt;
            if (u > (64'sd1 <<< FB)) u = 64'sd1 <<< FB;
        end
        xv = kx[ia] & kx[ib];
        ha = kh[ia];
        hb = kh[ib];
        raw = hb - ha;
        if (raw > 32768) raw -= 65536;
        else if (raw < -32768) raw += 65536;
        n = xv ? 4 : 1;
        for (int p = 0; p < n; p++) begin
            f = '0;
            f.status = ST_OK;
            f.point_id = p[1:0];
            f.px = lerp_q16(signed'(kc[ia*12+p*3]), signed'(kc[ib*12+p*3]), u);
            f.py = lerp_q16(signed'(kc[ia*12+p*3+1]), signed'(kc[ib*12+p*3+1]), u);
            z = lerp_q16(signed'(kc[ia*12+p*3+2]), signed'(kc[ib*12+p*3+2]), u)
                + longint'(signed'(hoffset));
            if (z > 64'sd2147483647) z = 64'sd2147483647;
            if (z < -64'sd2147483648) z = -64'sd2147483648;
            f.pz = z[31:0];
            f.hdg = (p == 0) ? 16'(lerp_q16(ha, ha + raw, u)) : 16'd0;
            f.xvalid = xv;
            f.last = (p == n - 1);
            expected_frames.push_back(f);
        end
    endtask

    task automatic predict_request(logic [151:0] d, logic [7:0] us);
        kind_t k;
        logic [1:0] pt;
        int idx;
        k = kind_t'(us[1:0]);
        pt = us[3:2];
        case (k)
            KIND_LOAD: begin
                if (pt == PT_PAYLOAD) begin
                    if (kcount >= DEPTH) begin
                        dropped_tail = 1;
                        expected_frames.push_back(status_only(ST_FULL));
                        return;
                    end
                    idx = kcount;
                    kt[idx] = d[31:0];
                    kh[idx] = d[143:128];
                    kx[idx] = d[144];
                    kcount++;
                    dropped_tail = 0;
                end else begin
                    if (dropped_tail) begin
                        expected_frames.push_back(status_only(ST_FULL));
                        return;
                    end
                    if (kcount == 0) begin
                        expected_frames.push_back(status_only(ST_FEW));
                        return;
                    end
                    idx = kcount - 1;
                end
                kc[idx*12+pt*3]   = d[63:32];
                kc[idx*12+pt*3+1] = d[95:64];
                kc[idx*12+pt*3+2] = d[127:96];
                expected_frames.push_back(status_only(ST_OK));
            end
            KIND_QUERY: begin
                queries_seen++;
                predict_query(d[31:0]);
            end
            KIND_CLEAR: begin
                kcount = 0;
                dropped_tail = 0;
                expected_frames.push_back(status_only(ST_OK));
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        frame_out_t got, want;
        if (!aresetn) begin
            kcount <= 0;
            dropped_tail <= 0;
            hoffset <= 32'd72090;
        end else begin
            if (cfg_wr_en) hoffset = cfg_wr_data;
            if (s_tvalid && s_tready) predict_request(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got.status = m_tuser[1:0];
                got.point_id = m_tuser[3:2];
                got.px = m_tdata[31:0];
                got.py = m_tdata[63:32];
                got.pz = m_tdata[95:64];
                got.hdg = m_tdata[111:96];
                got.xvalid = m_tdata[112];
                got.last = m_tlast;
                results_seen++;
                if (expected_frames.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_frames.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
        pending = expected_frames.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        results_seen = 0;
        queries_seen = 0;
    end

endmodule

[tb/sv/keyframe_linear_interpolator_top_tb.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the keyframe linear interpolator: keyframe loads, queries
// and clears under random stalls; depends on kfi_pkg and keyframe_linear_interpolator_checker

module keyframe_linear_interpolator_top_tb;
    import kfi_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [7:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [119:0] m_tdata;
    logic [7:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en = 0;
    logic [31:0]  cfg_wr_data = '0;
    int           fail_count, pending, results_seen, queries_seen;
    int           idle_cycles = 0;
    int           requests_sent = 0;
    bit           rx_hold = 0;
    bit           rx_jitter = 1;
    logic [31:0]  tnow;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    keyframe_linear_interpolator_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    keyframe_linear_interpolator_checker i_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
        .queries_seen(queries_seen)
    );

    function automatic int gap_len();
        if ($urandom_range(9) < 7) return $urandom_range(1, 0) * $urandom_range(2);
        return $urandom_range(40, 5);
    endfunction

    // receiver: random stalls, always ready with jitter off, or a long hold when asked
    always @(posedge aclk) begin
        if (rx_hold) m_tready <= 0;
        else if (!rx_jitter) m_tready <= 1;
        else m_tready <= ($urandom_range(9) < 7);
    end

    // watchdog on accepted handshakes
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rx_hold)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("watchdog: no progress");
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(kind_t k, logic [1:0] pt, logic [31:0] t, logic [31:0] x,
                        logic [31:0] y, logic [31:0] z, logic [15:0] h, logic xp,
                        bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        repeat (g) @(posedge aclk);
        s_tvalid <= 1;
        s_tuser <= {4'd0, pt, k};
        s_tdata <= {7'd0, xp, h, z, y, x, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 0;
        requests_sent++;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_offset(logic [31:0] v);
        drain();
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    task automatic load_frame(logic [31:0] t, bit xp, bit all_pts);
        send(KIND_LOAD, PT_PAYLOAD, t, $urandom, $urandom, $urandom, $urandom, xp);
        if (all_pts)
            for (int p = 1; p <= PT_LAST; p++)
                send(KIND_LOAD, p[1:0], $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
    endtask

    task automatic random_query(logic [31:0] t0, logic [31:0] t1);
        logic [31:0] t;
        case ($urandom_range(5))
            0: t = $urandom;
            1: t = t0;
            2: t = t1;
            default: t = $urandom_range(t1, t0);
        endcase
        send(KIND_QUERY, 0, t, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table, lone extra point, too few frames
        send(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_LOAD, 2'd1, 0, 1, 2, 3, 0, 0);
        send(KIND_LOAD, PT_PAYLOAD, 32'h100, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             16'hfff0, 1);
        send(KIND_QUERY, 0, 32'h100, 0, 0, 0, 0, 0);
        for (int p = 1; p <= PT_LAST; p++)
            send(KIND_LOAD, p[1:0], 0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0);
        send(KIND_LOAD, PT_PAYLOAD, 32'h300, 32'h80000000, 32'h7fffffff, 32'h80000000,
             16'h0010, 1);
        for (int p = 1; p <= PT_LAST; p++)
            send(KIND_LOAD, p[1:0], 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
        send(KIND_QUERY, 0, 32'h0, 0, 0, 0, 0, 0);
        send(KIND_QUERY, 0, 32'h200, 0, 0, 0, 0, 0);
        send(KIND_QUERY, 0, 32'hffffffff, 0, 0, 0, 0, 0);
        // half turn heading difference, then equal times
        send(KIND_LOAD, PT_PAYLOAD, 32'h400, 0, 0, 0, 16'h8010, 0);
        send(KIND_QUERY, 0, 32'h380, 0, 0, 0, 0, 0);
        send(KIND_LOAD, PT_PAYLOAD, 32'h400, 1, 1, 1, 16'h0, 0);
        send(KIND_LOAD, PT_PAYLOAD, 32'h200, 5, 5, 5, 16'h1234, 0);
        send(KIND_QUERY, 0, 32'h3ff, 0, 0, 0, 0, 0);
        send(KIND_LOAD, PT_PAYLOAD, 32'hffffffff, 9, 9, 9, 16'hffff, 1);
        send(KIND_QUERY, 0, 32'hfffffffe, 0, 0, 0, 0, 0);
        send(KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_QUERY, 0, 32'h10, 0, 0, 0, 0, 0);

        // offset extremes, random sorted tables
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_offset(32'h7fffffff);
                1: write_offset(32'h80000000);
                2: write_offset($urandom);
                default: write_offset(32'd0);
            endcase
            send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
            tnow = $urandom_range(1000);
            for (int k = 0; k < 5; k++) begin
                load_frame(tnow, $urandom_range(3) != 0, $urandom_range(4) != 0);
                tnow += $urandom_range(200000, 0);
            end
            if (phase == 1) begin
                // hold the receiver while queries keep coming
                rx_hold = 1;
                fork
                    begin repeat (400) @(posedge aclk); rx_hold = 0; end
                    for (int q = 0; q < 8; q++) random_query(0, tnow);
                join
            end
            rx_jitter = (phase != 2);
            for (int q = 0; q < 25; q++) begin
                if ($urandom_range(15) == 0)
                    send(KIND_LOAD, $urandom_range(3), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
                else random_query(0, tnow);
            end
            rx_jitter = 1;
        end

        // fill the table to trigger the full-table drop
        drain();
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1);
        for (int k = 0; k < 1024; k++)
            send(KIND_LOAD, PT_PAYLOAD, k * 64, $urandom, $urandom, $urandom, $urandom,
                 0, 1);
        send(KIND_LOAD, PT_PAYLOAD, 0, 0, 0, 0, 0, 1);
        send(KIND_LOAD, 2'd2, 0, 1, 1, 1, 0, 0);
        send(KIND_QUERY, 0, 32'd1000, 0, 0, 0, 0, 0);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_LOAD, 2'd1, 0, 1, 1, 1, 0, 0);

        drain();
        $display("sent %0d requests, %0d queries, checked %0d results",
                 requests_sent, queries_seen, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[keyframe_linear_interpolator_top.f]
rtl/kfi_pkg.sv
rtl/kfi_ram.sv
rtl/kfi_div.sv
rtl/keyframe_linear_interpolator_top.sv
tb/sv/keyframe_linear_interpolator_checker.sv
tb/sv/keyframe_linear_interpolator_top_tb.sv
